/* rtl/cip_pkg.sv */
// shared widths and pipeline stage type for the condensed index to pair converter
`timescale 1ns / 1ps
`default_nettype none

package cip_pkg;

    // field widths
    localparam int NUM_W  = 16;
    localparam int IDX_W  = 31;

    // integer square root of 1 + 8k, two radicand bits per step
    localparam int RAD_W    = 34;
    localparam int ROOT_W   = 17;
    localparam int REM_W    = 20;
    localparam int SQ_STEPS = RAD_W / 2;

    // one stage of the square root pipe
    typedef struct packed {
        logic [NUM_W-1:0]  n;
        logic [IDX_W-1:0]  k;
        logic              err;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_sq;

endpackage

`default_nettype wire

/* rtl/condensed_index_to_pair.sv */
// top level: condensed distance vector index to (row, column) pair, fully pipelined
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+-----------------------------------
//  s_axis    | in  | i_s_tvalid / o_s_tready    | tdata[30:0] linear_index
//  m_axis    | out | o_m_tvalid / i_m_tready    | tdata[15:0] row, [31:16] col; tuser out_of_range
//  cfg       | in  | i_cfg_valid / o_cfg_ready  | num_points [15:0]
//
// one item per cycle unless the output stalls; the stages are: one for n(n-1), one for
// the range check, 17 stages of the square root (one root bit each), one stage for
// c(c+1) and the output register.
// reset (synchronous, active low) empties the pipe and sets num_points to 2.
// a stall at the output freezes the whole pipe; input ready follows output ready.
`timescale 1ns / 1ps
`default_nettype none

module condensed_index_to_pair #(
    parameter int MAX_POINTS = 65535
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // config write
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [cip_pkg::NUM_W-1:0] i_cfg_data,    // num_points
    // input stream
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [31:0]               i_s_tdata,     // [30:0] linear_index, [31] zero
    // output stream
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [31:0]                    o_m_tdata,     // [15:0] row_index, [31:16] col_index
    output logic [0:0]                     o_m_tuser      // [0] out_of_range
);
    import cip_pkg::*;

    logic [NUM_W-1:0] r_num_points;
    logic             en;

    // stage a
    logic             r_a_vld;
    logic [NUM_W-1:0] r_a_n;
    logic [IDX_W-1:0] r_a_idx;
    logic [31:0]      r_a_prod;
    logic [NUM_W-1:0] n_a_n;
    logic [NUM_W-1:0] n_a_nm1;

    // stage b
    logic             r_b_vld;
    t_sq              r_b;
    t_sq              n_b;
    logic [IDX_W-1:0] b_total;

    // square root stages
    logic             r_sq_vld [SQ_STEPS];
    t_sq              r_sq     [SQ_STEPS];
    t_sq              n_sq     [SQ_STEPS];

    // stage c
    logic              r_c_vld;
    logic [NUM_W-1:0]  r_c_n;
    logic [NUM_W-1:0]  r_c_k;
    logic              r_c_err;
    logic [NUM_W-1:0]  r_c_c;
    logic [32:0]       r_c_prod;
    logic [NUM_W-1:0]  n_c_c;
    logic [NUM_W:0]    n_c_cp1;

    // output register
    logic              r_out_vld;
    logic [31:0]       r_out_data;
    logic              r_out_err;
    logic [NUM_W-1:0]  n_row;
    logic [NUM_W-1:0]  n_col;

    // whole pipe moves unless the output holds an item that is not taken
    assign en          = !r_out_vld || i_m_tready;
    assign o_s_tready  = en;
    assign o_cfg_ready = 1'b1;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= NUM_W'(2);
        end else if (i_cfg_valid) begin
            r_num_points <= i_cfg_data;
        end
    end

    // stage a: saturate n and form n(n-1)
    always_comb begin
        n_a_n   = (32'(r_num_points) > 32'(MAX_POINTS)) ? NUM_W'(MAX_POINTS) : r_num_points;
        n_a_nm1 = (n_a_n == '0) ? '0 : n_a_n - NUM_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_n    <= n_a_n;
            r_a_idx  <= i_s_tdata[IDX_W-1:0];
            r_a_prod <= n_a_n * n_a_nm1;
        end
    end

    // stage b: range check, k = N - index, radicand 1 + 8k
    always_comb begin
        b_total  = r_a_prod[IDX_W:1];
        n_b.n    = r_a_n;
        n_b.err  = (r_a_idx == '0) || (r_a_idx > b_total);
        n_b.k    = b_total - r_a_idx;
        n_b.rem  = '0;
        n_b.root = '0;
        n_b.rad  = {n_b.k, 3'b001};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b <= n_b;
        end
    end

    // square root: each stage brings in two radicand bits and settles one root bit
    always_comb begin
        t_sq              src;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        for (int s = 0; s < SQ_STEPS; s++) begin
            src   = (s == 0) ? r_b : r_sq[(s == 0) ? 0 : s - 1];
            rem2  = {src.rem[REM_W-3:0], src.rad[RAD_W-1 -: 2]};
            trial = {1'b0, src.root, 2'b01};
            n_sq[s].n   = src.n;
            n_sq[s].k   = src.k;
            n_sq[s].err = src.err;
            n_sq[s].rad = {src.rad[RAD_W-3:0], 2'b00};
            if (rem2 >= trial) begin
                n_sq[s].rem  = rem2 - trial;
                n_sq[s].root = {src.root[ROOT_W-2:0], 1'b1};
            end else begin
                n_sq[s].rem  = rem2;
                n_sq[s].root = {src.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SQ_STEPS; s++) begin
                r_sq_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_sq_vld[0] <= r_b_vld;
            for (int s = 1; s < SQ_STEPS; s++) begin
                r_sq_vld[s] <= r_sq_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < SQ_STEPS; s++) begin
                r_sq[s] <= n_sq[s];
            end
        end
    end

    // stage c: c = (root - 1) / 2 and c(c+1)
    always_comb begin
        n_c_c   = NUM_W'((r_sq[SQ_STEPS-1].root - ROOT_W'(1)) >> 1);
        n_c_cp1 = {1'b0, n_c_c} + (NUM_W+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_sq_vld[SQ_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_n    <= r_sq[SQ_STEPS-1].n;
            r_c_k    <= r_sq[SQ_STEPS-1].k[NUM_W-1:0];
            r_c_err  <= r_sq[SQ_STEPS-1].err;
            r_c_c    <= n_c_c;
            r_c_prod <= n_c_c * n_c_cp1;
        end
    end

    // output stage: row = n-1-c, col = n-k+c(c+1)/2, zeroed on error
    always_comb begin
        n_row = r_c_n - NUM_W'(1) - r_c_c;
        n_col = r_c_n - r_c_k + r_c_prod[NUM_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= r_c_err ? '0 : {n_col, n_row};
            r_out_err  <= r_c_err;
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_err;

endmodule

`default_nettype wire

/* rtl/cip_checker.sv */
// port-level checker for the condensed index to pair converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module cip_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      o_s_tready,
    input  wire logic                      o_m_tvalid,
    input  wire logic                      i_m_tready,
    input  wire logic [31:0]               o_m_tdata,
    input  wire logic [0:0]                o_m_tuser
);
    import cip_pkg::*;

    // an error item carries a zero pair
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("out_of_range item with nonzero pair");

    // a good item names a pair with 1 <= row < col
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |->
            (o_m_tdata[NUM_W-1:0] != '0) && (o_m_tdata[NUM_W-1:0] < o_m_tdata[31:NUM_W]))
        else $error("row not below column");

    // input is never refused while the output side is empty
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // a stalled output item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output item changed");

endmodule

bind condensed_index_to_pair cip_checker u_cip_checker (.*);

`default_nettype wire

/* bench/condensed_index_to_pair_test.sv */
// self-checking testbench for the condensed index to pair converter
`timescale 1ns / 1ps

module condensed_index_to_pair_test;
    import cip_pkg::*;

    typedef enum logic {STIM_INDEX, STIM_POINTS} t_stim_kind;

    // one pending stimulus entry: an index item or a new object count
    typedef struct {
        t_stim_kind       kind;
        logic [IDX_W-1:0] idx;
        logic [NUM_W-1:0] points;
    } t_stim;

    typedef struct packed {
        logic [NUM_W-1:0] row;
        logic [NUM_W-1:0] col;
        logic             bad;
    } t_pair;

    localparam int               IDLE_LIMIT   = 2000;
    localparam int               DRAIN_CYCLES = 40;
    localparam int               NUM_ITEMS    = 1950;
    localparam logic [NUM_W-1:0] RESET_POINTS = NUM_W'(2);
    localparam logic [NUM_W-1:0] TOP_POINTS   = NUM_W'(65535);

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [NUM_W-1:0] i_cfg_data  = '0;
    logic             i_s_tvalid  = 1'b0;
    logic             o_s_tready;
    logic [31:0]      i_s_tdata   = '0;    // [30:0] linear_index, [31] zero
    logic             o_m_tvalid;
    logic             i_m_tready  = 1'b0;
    logic [31:0]      o_m_tdata;           // [15:0] row_index, [31:16] col_index
    logic [0:0]       o_m_tuser;           // [0] out_of_range

    t_stim stim_q[$];
    t_pair pair_q[$];
    int    results_owed = 0;
    int    errors       = 0;
    int    items_queued = 0;
    logic  calm         = 1'b0;
    int    calm_left    = 0;
    int    gap_left     = 0;
    int    stall_left   = 0;
    int    idle_cycles  = 0;
    logic [NUM_W-1:0] points_now = RESET_POINTS;

    condensed_index_to_pair dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // number of pairs n(n-1)/2, zero below two objects
    function automatic longint unsigned pair_count(input logic [NUM_W-1:0] n);
        longint unsigned w;
        w = n;
        return (w >= 2) ? w * (w - 1) / 2 : 0;
    endfunction

    // exact floor of the square root by bisection
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd1 << 18;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // expected pair for one index under object count n
    function automatic t_pair locate_pair(input logic [IDX_W-1:0] idx,
                                          input logic [NUM_W-1:0] n);
        t_pair           p;
        longint unsigned total, k, c, tri_sum, nn;
        p     = '0;
        nn    = n;    // a 16 bit count never exceeds MAX_POINTS, so no saturation
        total = pair_count(n);
        if (idx == 0 || idx > total) begin
            p.bad = 1'b1;
            return p;
        end
        k       = total - idx;
        c       = (floor_sqrt(1 + 8 * k) - 1) / 2;
        tri_sum = c * (c + 1) / 2;
        p.row   = NUM_W'(nn - 1 - c);
        p.col   = NUM_W'(nn - (k - tri_sum));
        return p;
    endfunction

    // idle length: none when quiet, else mostly none or short, now and then long
    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic add_index(input logic [IDX_W-1:0] idx);
        t_stim s;
        s.kind   = STIM_INDEX;
        s.idx    = idx;
        s.points = '0;
        stim_q.push_back(s);
        items_queued++;
    endtask

    task automatic add_points(input logic [NUM_W-1:0] n);
        t_stim s;
        s.kind   = STIM_POINTS;
        s.idx    = '0;
        s.points = n;
        stim_q.push_back(s);
    endtask

    // stretches of random idling alternate with stretches of none
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(50, 300);
        end else begin
            calm_left--;
        end
    end

    // output side: random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap(calm);
        end
    end

    // driver: index items and object count writes from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else if ((i_s_tvalid && !o_s_tready) || (i_cfg_valid && !o_cfg_ready)) begin
            // hold the item until it is taken
        end else if (gap_left > 0) begin
            i_s_tvalid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_left--;
        end else if (stim_q.size() == 0) begin
            i_s_tvalid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else if (stim_q[0].kind == STIM_POINTS) begin
            i_s_tvalid <= 1'b0;
            // write the count only once the pipe has drained
            if (results_owed == 0 && !i_s_tvalid && !i_cfg_valid) begin
                i_cfg_valid <= 1'b1;
                i_cfg_data  <= stim_q[0].points;
                void'(stim_q.pop_front());
                gap_left = pick_gap(calm);
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end else begin
            i_cfg_valid <= 1'b0;
            i_s_tvalid  <= 1'b1;
            i_s_tdata   <= {1'b0, stim_q[0].idx};
            void'(stim_q.pop_front());
            gap_left = pick_gap(calm);
        end
    end

    // monitor: predict on input, compare on output, watchdog
    always @(posedge i_clk) begin
        t_pair got, want;
        logic  moved;
        moved = 1'b0;
        if (o_m_tvalid && i_m_tready) begin
            moved   = 1'b1;
            got.row = o_m_tdata[15:0];
            got.col = o_m_tdata[31:16];
            got.bad = o_m_tuser[0];
            if (pair_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item row %0d col %0d out_of_range %0b",
                         $time, got.row, got.col, got.bad);
            end else begin
                want = pair_q.pop_front();
                if (got.row !== want.row) begin
                    errors++;
                    $display("%0t: row_index expected %0d actual %0d",
                             $time, want.row, got.row);
                end
                if (got.col !== want.col) begin
                    errors++;
                    $display("%0t: col_index expected %0d actual %0d",
                             $time, want.col, got.col);
                end
                if (got.bad !== want.bad) begin
                    errors++;
                    $display("%0t: out_of_range expected %0b actual %0b",
                             $time, want.bad, got.bad);
                end
            end
        end
        if (i_s_tvalid && o_s_tready) begin
            moved = 1'b1;
            pair_q.push_back(locate_pair(i_s_tdata[IDX_W-1:0], points_now));
        end
        if (i_cfg_valid && o_cfg_ready) begin
            moved      = 1'b1;
            points_now = i_cfg_data;
        end
        results_owed <= pair_q.size();

        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL condensed_index_to_pair");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int               r, phase_len;
        logic [NUM_W-1:0] n;
        longint unsigned  total;
        logic [IDX_W-1:0] idx;

        // directed: two objects after reset, single pair only
        add_index('0);
        add_index(IDX_W'(1));
        add_index(IDX_W'(2));
        add_index('1);
        // no objects and one object: everything out of range
        add_points(NUM_W'(0));
        add_index('0);
        add_index(IDX_W'(1));
        add_points(NUM_W'(1));
        add_index(IDX_W'(1));
        // largest count: first row, last pair and just past it
        add_points(TOP_POINTS);
        add_index(IDX_W'(1));
        add_index(IDX_W'(TOP_POINTS - 1));
        add_index(IDX_W'(TOP_POINTS));
        add_index(IDX_W'(pair_count(TOP_POINTS)));
        add_index(IDX_W'(pair_count(TOP_POINTS) + 1));
        add_index('1);
        // four objects: walk every pair and one past the end
        add_points(NUM_W'(4));
        for (int i = 1; i <= 7; i++) add_index(IDX_W'(i));

        // random phases, each under a fresh object count
        while (items_queued < NUM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 35) n = NUM_W'($urandom_range(2, 20));
            else if (r < 60) n = NUM_W'($urandom_range(21, 400));
            else if (r < 80) n = NUM_W'($urandom_range(401, 65535));
            else if (r < 90) n = NUM_W'($urandom());
            else begin
                case ($urandom_range(0, 3))
                    0:       n = NUM_W'(0);
                    1:       n = NUM_W'(1);
                    2:       n = RESET_POINTS;
                    default: n = TOP_POINTS;
                endcase
            end
            add_points(n);
            total     = pair_count(n);
            phase_len = $urandom_range(10, 80);
            for (int i = 0; i < phase_len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 80 && total > 0) begin
                    idx = IDX_W'($urandom_range(1, 32'(total)));
                end else if (r < 90) begin
                    case ($urandom_range(0, 2))
                        0:       idx = '0;
                        1:       idx = IDX_W'(total);
                        default: idx = IDX_W'(total + 1);
                    endcase
                end else begin
                    idx = IDX_W'($urandom());
                end
                add_index(idx);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_s_tvalid || i_cfg_valid || results_owed != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("PASS condensed_index_to_pair");
        else
            $display("FAIL condensed_index_to_pair");
        $finish;
    end

endmodule
